FILE: rtl/core/sede_pkg.sv
// Shared types and constants for the squared distance engine.
// No dependencies; imported by sede_sqrt and the top level.
`timescale 1ns / 1ps

package sede_pkg;

  localparam int DATA_W        = 16;  // Q8.8 element
  localparam int IDX_W         = 10;
  localparam int LEN_W         = 11;
  localparam int SUM_W         = 43;  // Q27.16 sum
  localparam int ROW_W         = 16;
  localparam int MAG_W         = 16;  // |q - v| never exceeds 65535
  localparam int SQ_W          = 2 * MAG_W;
  localparam int ROOT_W        = 22;  // ceil(SUM_W / 2)
  localparam int REM_W         = ROOT_W + 2;
  localparam int CFG_W         = LEN_W;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_DIM_DEF   = 1024;
  localparam int LEN_CAP_LIMIT = 1024;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ROW  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_LENGTH  = 1'b0,
    CFG_EUCLIDEAN_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_ACC,
    ST_ROOT,
    ST_EMIT
  } state_t;

  // handshake between the control and the root unit
  typedef struct packed {
    logic start;
    logic done;
  } root_ctl_t;

endpackage

FILE: rtl/core/sede_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sede_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sede_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on sede_pkg.
`timescale 1ns / 1ps

module sede_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sede_pkg::SUM_W-1:0]  radicand,
  output logic                        done,
  output logic [sede_pkg::ROOT_W-1:0] root
);

  import sede_pkg::*;

  localparam int X_W   = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [X_W-1:0]    x_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r, x_r[X_W-1 -: 2]};
    trial  = (REM_W + 2)'({root_r, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(ROOT_W - 1);
        x_r    <= X_W'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r    <= {x_r[X_W-3:0], 2'b00};
        rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], fits};
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == '0);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/core/squared_euclidean_distance_engine.sv
// Squared / Euclidean distance engine, top level. Uses sede_pkg, sede_ram, sede_sqrt.
// Query load: one item per cycle while idle. A row element passes the query read, diff,
// square and accumulate steps while the input is stalled. At the end of a row the
// result goes to the emit state, in Euclidean mode after the 22-step root unit.
// Synchronous active-low reset clears control, sum and row count; the query RAM
// is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module squared_euclidean_distance_engine #(
  parameter int MAX_DIM = sede_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [sede_pkg::IDX_W-1:0]     in_element_index,
  input  logic signed [sede_pkg::DATA_W-1:0] in_element_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sede_pkg::SUM_W-1:0]     out_distance,
  output logic [sede_pkg::ROW_W-1:0]     out_row_number,
  input  logic                           cfg_we,
  input  logic [sede_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sede_pkg::CFG_W-1:0]     cfg_wdata
);

  import sede_pkg::*;

  localparam int AW  = $clog2(MAX_DIM);
  localparam int CAP = (MAX_DIM < LEN_CAP_LIMIT) ? MAX_DIM : LEN_CAP_LIMIT;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]         vlen_r;
  logic                     emode_r;
  logic [LEN_W-1:0]         len_eff;

  logic signed [DATA_W-1:0] val_r;
  logic                     first_r;
  logic                     last_r;
  logic [MAG_W-1:0]         mag_r;
  logic [SQ_W-1:0]          sq_r;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [SUM_W-1:0]         res_r;
  logic [ROW_W-1:0]         rows_done_r;

  logic                     out_valid_r;
  logic [SUM_W-1:0]         out_distance_r;
  logic [ROW_W-1:0]         out_row_r;

  logic                     accept;
  logic                     is_load;
  logic                     load_ok;
  logic                     row_ok;
  logic [IDX_W+AW-1:0]      idx_ext;
  logic [AW-1:0]            addr;
  logic [DATA_W-1:0]        q_rdata;
  logic signed [DATA_W:0]   diff;
  logic [SUM_W:0]           add_full;
  logic                     out_free;
  logic                     emit;
  logic                     root_start;

  root_ctl_t                root_ctl;
  logic [ROOT_W-1:0]        root_val;

  // effective length clamped into [1, CAP]
  always_comb begin
    if (vlen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (vlen_r > LEN_W'(CAP)) begin
      len_eff = LEN_W'(CAP);
    end else begin
      len_eff = vlen_r;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_load  = (op_t'(in_op) == OP_LOAD);
  assign load_ok  = (32'(in_element_index) < 32'(MAX_DIM));
  assign row_ok   = ({1'b0, in_element_index} < len_eff);
  assign idx_ext  = {{AW{1'b0}}, in_element_index};
  assign addr     = idx_ext[AW-1:0];

  sede_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_DIM)
  ) u_query_ram (
    .clk  (clk),
    .we   (accept && is_load && load_ok),
    .waddr(addr),
    .wdata(in_element_value),
    .raddr(addr),
    .rdata(q_rdata)
  );

  assign diff     = {q_rdata[DATA_W-1], q_rdata} - {val_r[DATA_W-1], val_r};
  assign add_full = {1'b0, (first_r ? {SUM_W{1'b0}} : sum_r)} + (SUM_W + 1)'(sq_r);
  assign out_free = !out_valid_r || !out_stall;

  assign root_ctl.start = root_start;

  sede_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_ctl.start),
    .radicand(sum_nxt),
    .done    (root_ctl.done),
    .root    (root_val)
  );

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    root_start = 1'b0;
    emit       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && !is_load && row_ok) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ACC;
      ST_ACC: begin
        // saturates only when indices repeat without a restart
        sum_nxt = add_full[SUM_W] ? SUM_MAX : add_full[SUM_W-1:0];
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (emode_r) begin
          root_start = 1'b1;
          state_nxt  = ST_ROOT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ROOT: begin
        if (root_ctl.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vlen_r      <= LEN_W'(1);
      emode_r     <= 1'b0;
      sum_r       <= '0;
      rows_done_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VECTOR_LENGTH:  vlen_r  <= cfg_wdata;
          CFG_EUCLIDEAN_MODE: emode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        rows_done_r <= rows_done_r + 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r   <= in_element_value;
      first_r <= (in_element_index == '0);
      last_r  <= ({1'b0, in_element_index} == len_eff - 1'b1);
    end
    if (state_r == ST_DIFF) begin
      mag_r <= diff[DATA_W] ? MAG_W'(-diff) : MAG_W'(diff);
    end
    if (state_r == ST_SQ) begin
      sq_r <= mag_r * mag_r;
    end
    if (state_r == ST_ACC) begin
      res_r <= sum_nxt;
    end else if (state_r == ST_ROOT && root_ctl.done) begin
      res_r <= SUM_W'(root_val);
    end
    if (emit) begin
      out_distance_r <= res_r;
      out_row_r      <= rows_done_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_distance_r;
  assign out_row_number = out_row_r;

endmodule
